>>> design/dosc_pkg.sv
// Shared types, constants and helpers for the damped oscillator Euler step.
`default_nettype none

package dosc_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_DIM_COUNT = 3'd0;
  localparam logic [2:0] REG_STIFFNESS = 3'd1;
  localparam logic [2:0] REG_DAMPING   = 3'd2;
  localparam logic [2:0] REG_WRAP_EN   = 3'd3;
  localparam logic [2:0] REG_LOWER     = 3'd4;
  localparam logic [2:0] REG_UPPER     = 3'd5;
  localparam logic [2:0] REG_INIT_POS  = 3'd6;

  // Reset values of the configuration registers
  localparam logic [3:0]         DIM_COUNT_RESET = 4'd2;
  localparam logic [31:0]        GAIN_RESET      = 32'h0004_0000;  // 4.0
  localparam logic signed [31:0] INIT_POS_RESET  = 32'sh0004_0000; // 4.0

  // Multiplier operand selects
  localparam logic [2:0] MUL_NONE   = 3'd0;
  localparam logic [2:0] MUL_K_ERR  = 3'd1;
  localparam logic [2:0] MUL_B_VEL  = 3'd2;
  localparam logic [2:0] MUL_DT_ACC = 3'd3;
  localparam logic [2:0] MUL_DT_VEL = 3'd4;

  // Datapath register operations
  localparam logic [2:0] OP_NONE    = 3'd0;
  localparam logic [2:0] OP_ERR     = 3'd1;
  localparam logic [2:0] OP_TERM    = 3'd2;
  localparam logic [2:0] OP_ACC     = 3'd3;
  localparam logic [2:0] OP_VEL     = 3'd4;
  localparam logic [2:0] OP_POS     = 3'd5;
  localparam logic [2:0] OP_WRAP_HI = 3'd6;
  localparam logic [2:0] OP_WRAP_LO = 3'd7;

  // Sequencer jump kinds
  localparam logic [1:0] JMP_NEXT      = 2'd0;
  localparam logic [1:0] JMP_IF_NOWRAP = 2'd1;
  localparam logic [1:0] JMP_FINISH    = 2'd2;

  localparam int STEP_W    = 4;
  localparam int WIDE_W    = 53;
  localparam int PROD_W    = 68;
  localparam int TERM_W    = PROD_W - 16;
  localparam int LAST_STEP = 10;

  // One microcode word
  typedef struct packed {
    logic [2:0]        mul_sel;
    logic [2:0]        op;
    logic [1:0]        jmp;
    logic [STEP_W-1:0] target;
  } ucode_t;

  // Controls from the sequencer to the datapath
  typedef struct packed {
    logic       load;
    logic       commit;
    logic [2:0] mul_sel;
    logic [2:0] op;
  } dp_ctl_t;

  // Saturate a wide signed value to Q16.16
  function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = {{(WIDE_W-32){1'b0}}, 32'h7fff_ffff};
    lo = {{(WIDE_W-32){1'b1}}, 32'h8000_0000};
    if (v > hi) begin
      sat32 = 32'sh7fff_ffff;
    end else if (v < lo) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

`default_nettype wire

>>> design/dosc_ucode_rom.sv
// Microcode program of the oscillator step sequencer.
`default_nettype none

module dosc_ucode_rom
  import dosc_pkg::*;
(
  input  wire logic [STEP_W-1:0] pc,
  output ucode_t                 word
);

  // mul_sel, op, jump kind, jump target
  always_comb begin
    unique case (pc)
      4'd0:    word = '{MUL_NONE,   OP_ERR,     JMP_NEXT,      4'd0};
      4'd1:    word = '{MUL_K_ERR,  OP_NONE,    JMP_NEXT,      4'd0};
      4'd2:    word = '{MUL_B_VEL,  OP_TERM,    JMP_NEXT,      4'd0};
      4'd3:    word = '{MUL_NONE,   OP_ACC,     JMP_NEXT,      4'd0};
      4'd4:    word = '{MUL_DT_ACC, OP_NONE,    JMP_NEXT,      4'd0};
      4'd5:    word = '{MUL_NONE,   OP_VEL,     JMP_NEXT,      4'd0};
      4'd6:    word = '{MUL_DT_VEL, OP_NONE,    JMP_NEXT,      4'd0};
      4'd7:    word = '{MUL_NONE,   OP_POS,     JMP_IF_NOWRAP, 4'd10};
      4'd8:    word = '{MUL_NONE,   OP_WRAP_HI, JMP_NEXT,      4'd0};
      4'd9:    word = '{MUL_NONE,   OP_WRAP_LO, JMP_NEXT,      4'd0};
      default: word = '{MUL_NONE,   OP_NONE,    JMP_FINISH,    4'd0};
    endcase
  end

endmodule

`default_nettype wire

>>> design/dosc_datapath.sv
// Oscillator datapath: state stores, shared multiplier and working registers.
`default_nettype none

module dosc_datapath
  import dosc_pkg::*;
#(
  parameter int MAX_DIMS = 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire dp_ctl_t            ctl,
  input  wire logic [2:0]         dim_index,
  input  wire logic signed [31:0] target,
  input  wire logic signed [31:0] override_value,
  input  wire logic               override_active,
  input  wire logic [15:0]        time_step,
  input  wire logic [31:0]        stiffness,
  input  wire logic [31:0]        damping_gain,
  input  wire logic               wrap_enable,
  input  wire logic signed [31:0] lower_limit,
  input  wire logic signed [31:0] upper_limit,
  input  wire logic               reload,
  input  wire logic signed [31:0] reload_pos,
  output logic [2:0]              dim,
  output logic signed [31:0]      pos,
  output logic signed [31:0]      vel,
  output logic signed [31:0]      acc
);

  localparam int IDX_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

  logic signed [31:0] pos_store [MAX_DIMS];
  logic signed [31:0] vel_store [MAX_DIMS];

  logic [IDX_W-1:0]         idx;
  logic signed [31:0]       lam;
  logic [15:0]              dt;
  logic signed [31:0]       err;
  logic signed [PROD_W-1:0] prod;
  logic signed [TERM_W-1:0] term;
  logic signed [35:0]       wpos;

  logic signed [32:0]       diff;
  logic [32:0]              mag;
  logic signed [34:0]       twice_mag;
  logic signed [34:0]       lim_sum;
  logic signed [34:0]       err_wide;
  logic signed [33:0]       mul_a;
  logic signed [33:0]       mul_b;
  logic signed [TERM_W-1:0] prod_fl;
  logic signed [35:0]       lower_x;
  logic signed [35:0]       upper_x;
  logic signed [35:0]       pos_x;
  logic signed [35:0]       wrap_lo_val;

  assign dim = 3'(idx);

  // Error, with cyclic wrap against the mean of the limits
  always_comb begin
    diff      = {pos[31], pos} - {lam[31], lam};
    mag       = diff[32] ? 33'(-diff) : 33'(diff);
    twice_mag = {1'b0, mag, 1'b0};
    lim_sum   = {{3{upper_limit[31]}}, upper_limit} + {{3{lower_limit[31]}}, lower_limit};
    err_wide  = {{2{diff[32]}}, diff};
    if (wrap_enable && (twice_mag > lim_sum)) begin
      if (diff[32]) begin
        err_wide = {{2{diff[32]}}, diff} + {{3{upper_limit[31]}}, upper_limit};
      end else begin
        err_wide = {{2{diff[32]}}, diff} - {{3{upper_limit[31]}}, upper_limit};
      end
    end
  end

  // Shared multiplier operand select
  always_comb begin
    unique case (ctl.mul_sel)
      MUL_K_ERR: begin
        mul_a = {2'b0, stiffness};
        mul_b = -{{2{err[31]}}, err};
      end
      MUL_B_VEL: begin
        mul_a = {2'b0, damping_gain};
        mul_b = {{2{vel[31]}}, vel};
      end
      MUL_DT_ACC: begin
        mul_a = {18'b0, dt};
        mul_b = {{2{acc[31]}}, acc};
      end
      MUL_DT_VEL: begin
        mul_a = {18'b0, dt};
        mul_b = {{2{vel[31]}}, vel};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Floor of the registered product by 2^16
  assign prod_fl = prod[PROD_W-1:16];

  // Cyclic position fold helpers
  always_comb begin
    lower_x = {{4{lower_limit[31]}}, lower_limit};
    upper_x = {{4{upper_limit[31]}}, upper_limit};
    pos_x   = {{4{pos[31]}}, pos};
    if (wpos < lower_x) begin
      wrap_lo_val = upper_x + wpos - lower_x;
    end else begin
      wrap_lo_val = wpos;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (ctl.mul_sel != MUL_NONE) begin
      prod <= mul_a * mul_b;
    end
    if (ctl.load) begin
      idx <= IDX_W'(dim_index);
      dt  <= time_step;
      vel <= vel_store[IDX_W'(dim_index)];
      if (override_active) begin
        pos <= override_value;
        lam <= override_value;
      end else begin
        pos <= pos_store[IDX_W'(dim_index)];
        lam <= target;
      end
    end else begin
      unique case (ctl.op)
        OP_ERR:  err  <= sat32({{(WIDE_W-35){err_wide[34]}}, err_wide});
        OP_TERM: term <= prod_fl;
        OP_ACC:  acc  <= sat32({term[TERM_W-1], term} - {prod_fl[TERM_W-1], prod_fl});
        OP_VEL:  vel  <= sat32({{(WIDE_W-32){vel[31]}}, vel}
                               + {prod_fl[TERM_W-1], prod_fl});
        OP_POS:  pos  <= sat32({{(WIDE_W-32){pos[31]}}, pos}
                               + {prod_fl[TERM_W-1], prod_fl});
        OP_WRAP_HI: begin
          if (pos > upper_limit) begin
            wpos <= lower_x + pos_x - upper_x;
          end else begin
            wpos <= pos_x;
          end
        end
        OP_WRAP_LO: pos <= sat32({{(WIDE_W-36){wrap_lo_val[35]}}, wrap_lo_val});
        default: ;
      endcase
    end
  end

  // Per-dimension state; reset and reload set every entry at once
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_DIMS; i++) begin
        pos_store[i] <= INIT_POS_RESET;
        vel_store[i] <= '0;
      end
    end else if (reload) begin
      for (int i = 0; i < MAX_DIMS; i++) begin
        pos_store[i] <= reload_pos;
        vel_store[i] <= '0;
      end
    end else if (ctl.commit) begin
      pos_store[idx] <= pos;
      vel_store[idx] <= vel;
    end
  end

endmodule

`default_nettype wire

>>> design/damped_oscillator_euler_step.sv
// Top level: configuration registers, microcode sequencer and result register.
//
//   channel | direction | handshake           | beat
//   --------+-----------+---------------------+-----------------------------------------
//   in      | in        | in_valid / in_stall | dim_index, target, override_value,
//           |           |                     | override_active, time_step
//   out     | out       | out_valid/out_stall | dim_out, position_out, velocity_out,
//           |           |                     | acceleration_out
//   cfg     | in        | cfg_write           | cfg_index, cfg_data
//
// An active beat is taken, then the sequencer runs 8 steps (10 in cyclic mode),
// plus a finish step that waits for a free result register.
// A new beat is taken the cycle after the finish step, and not before the last beat
// is through, as the four dependent products share the one multiplier.
// A beat for an unused dimension is taken without starting the sequencer and gives no result.
// in_stall is high while the sequencer is busy; the result register lets the sequencer
// take a new beat while out_stall holds the last result, but the finish step waits until it is taken.
// Synchronous reset loads every position with 4.0 and clears every velocity.
`default_nettype none

module damped_oscillator_euler_step
  import dosc_pkg::*;
#(
  parameter int MAX_DIMS = 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [2:0]         dim_index,
  input  wire logic signed [31:0] target,
  input  wire logic signed [31:0] override_value,
  input  wire logic               override_active,
  input  wire logic [15:0]        time_step,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [2:0]              dim_out,
  output logic signed [31:0]      position_out,
  output logic signed [31:0]      velocity_out,
  output logic signed [31:0]      acceleration_out,
  input  wire logic               cfg_write,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);

  localparam logic [4:0] MAX_DIMS_W = 5'(MAX_DIMS);

  logic [3:0]         dim_count;
  logic [31:0]        stiffness;
  logic [31:0]        damping_gain;
  logic               wrap_enable;
  logic signed [31:0] lower_limit;
  logic signed [31:0] upper_limit;
  logic signed [31:0] initial_position;

  logic              busy;
  logic [STEP_W-1:0] pc;
  logic [STEP_W-1:0] pc_next;
  ucode_t            word;
  dp_ctl_t           ctl;

  logic               accept;
  logic               active;
  logic               out_free;
  logic               finish;
  logic               reload;
  logic signed [31:0] reload_pos;
  logic [4:0]         cnt_wr;
  logic [2:0]         dp_dim;
  logic signed [31:0] dp_pos;
  logic signed [31:0] dp_vel;
  logic signed [31:0] dp_acc;

  // Input handshake and dimension check
  assign in_stall = busy;
  assign accept   = in_valid && !busy;
  assign active   = ({1'b0, dim_index} < dim_count) && ({2'b0, dim_index} < MAX_DIMS_W);
  assign out_free = !out_valid || !out_stall;
  assign finish   = busy && (word.jmp == JMP_FINISH) && out_free;

  // Configuration registers
  assign cnt_wr = {1'b0, cfg_data[3:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      dim_count        <= DIM_COUNT_RESET;
      stiffness        <= GAIN_RESET;
      damping_gain     <= GAIN_RESET;
      wrap_enable      <= 1'b0;
      lower_limit      <= '0;
      upper_limit      <= '0;
      initial_position <= INIT_POS_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DIM_COUNT: begin
          if (cnt_wr == 5'd0) begin
            dim_count <= 4'd1;
          end else if (cnt_wr > MAX_DIMS_W) begin
            dim_count <= MAX_DIMS_W[3:0];
          end else begin
            dim_count <= cnt_wr[3:0];
          end
        end
        REG_STIFFNESS: stiffness        <= cfg_data;
        REG_DAMPING:   damping_gain     <= cfg_data;
        REG_WRAP_EN:   wrap_enable      <= cfg_data[0];
        REG_LOWER:     lower_limit      <= cfg_data;
        REG_UPPER:     upper_limit      <= cfg_data;
        REG_INIT_POS:  initial_position <= cfg_data;
        default: ;
      endcase
    end
  end

  // Writing the count or the start position restarts every dimension
  assign reload     = cfg_write && ((cfg_index == REG_DIM_COUNT) || (cfg_index == REG_INIT_POS));
  assign reload_pos = (cfg_index == REG_INIT_POS) ? cfg_data : initial_position;

  // Microcode fetch and sequencing
  dosc_ucode_rom u_rom (
    .pc   (pc),
    .word (word)
  );

  always_comb begin
    unique case (word.jmp)
      JMP_IF_NOWRAP: pc_next = wrap_enable ? pc + 1'b1 : word.target;
      JMP_FINISH:    pc_next = pc;
      default:       pc_next = pc + 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= '0;
    end else if (!busy) begin
      if (accept && active) begin
        busy <= 1'b1;
        pc   <= '0;
      end
    end else if (finish) begin
      busy <= 1'b0;
    end else begin
      pc <= pc_next;
    end
  end

  // Datapath controls
  always_comb begin
    ctl.load    = accept && active;
    ctl.commit  = finish;
    ctl.mul_sel = busy ? word.mul_sel : MUL_NONE;
    ctl.op      = busy ? word.op : OP_NONE;
  end

  dosc_datapath #(
    .MAX_DIMS (MAX_DIMS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .ctl             (ctl),
    .dim_index       (dim_index),
    .target          (target),
    .override_value  (override_value),
    .override_active (override_active),
    .time_step       (time_step),
    .stiffness       (stiffness),
    .damping_gain    (damping_gain),
    .wrap_enable     (wrap_enable),
    .lower_limit     (lower_limit),
    .upper_limit     (upper_limit),
    .reload          (reload),
    .reload_pos      (reload_pos),
    .dim             (dp_dim),
    .pos             (dp_pos),
    .vel             (dp_vel),
    .acc             (dp_acc)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      dim_out          <= dp_dim;
      position_out     <= dp_pos;
      velocity_out     <= dp_vel;
      acceleration_out <= dp_acc;
    end
  end

  // Checks
  a_start: assert property (@(posedge clk) disable iff (rst)
    (accept && active) |=> (busy && (pc == '0)))
    else $error("active beat did not start the sequencer");

  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (pc <= STEP_W'(LAST_STEP)))
    else $error("step counter ran past the program");

  a_finish_out: assert property (@(posedge clk) disable iff (rst)
    finish |=> (out_valid && !busy))
    else $error("finish did not hand over a result");

  a_no_skip: assert property (@(posedge clk) disable iff (rst)
    (busy && out_valid && out_stall) |=> busy)
    else $error("sequencer retired while the result register was held");

endmodule

`default_nettype wire
